// ----- src/assert_macros.svh -----
// Assertion macros used by the checker module of the conditioner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Checks that a consequent holds whenever an antecedent holds.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

// ----- src/ardc_pkg.sv -----
// Package with the request, result and configuration types of the conditioner.
`default_nettype none

package ardc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLIP_MASK       = 2'd0,
        CFG_RESOLUTION_BITS = 2'd1,
        CFG_DEADZONE        = 2'd2,
        CFG_ONE_SIDED_MASK  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
    } t_axis_in;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
    } t_axis_out;

    typedef struct packed {
        logic [2:0]  flip_mask;
        logic [3:0]  resolution_bits;
        logic [13:0] deadzone;
        logic [2:0]  one_sided_mask;
    } t_cfg;

endpackage

`default_nettype wire

// ----- src/ardc_div.sv -----
// Pipelined restoring divider that produces one quotient bit per stage.
`default_nettype none

module ardc_div #(
    parameter int NW = 31,
    parameter int DW = 14,
    parameter int QB = 17,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [QB-1:0] o_quo,
    output logic [PW-1:0] o_pay
);

    // The dividend bits above the quotient width must form a value below the divisor.
    logic          w_v   [0:QB];
    logic [DW-1:0] w_rem [0:QB];
    logic [QB-1:0] w_lo  [0:QB];
    logic [QB-1:0] w_quo [0:QB];
    logic [DW-1:0] w_den [0:QB];
    logic [PW-1:0] w_pay [0:QB];

    assign w_v[0]   = i_valid;
    assign w_rem[0] = DW'(i_num >> QB);
    assign w_lo[0]  = i_num[QB-1:0];
    assign w_quo[0] = '0;
    assign w_den[0] = i_den;
    assign w_pay[0] = i_pay;

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic          r_v;
        logic [DW-1:0] r_rem;
        logic [QB-1:0] r_lo;
        logic [QB-1:0] r_quo;
        logic [DW-1:0] r_den;
        logic [PW-1:0] r_pay;
        logic [DW:0]   w_try;
        logic          w_ge;
        logic [DW-1:0] n_rem;

        assign w_try = {w_rem[k], w_lo[k][QB-1-k]};
        assign w_ge  = (w_try >= {1'b0, w_den[k]});
        assign n_rem = w_ge ? DW'(w_try - {1'b0, w_den[k]}) : DW'(w_try);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= w_v[k];
            end
            r_rem <= n_rem;
            r_lo  <= w_lo[k];
            r_quo <= {w_quo[k][QB-2:0], w_ge};
            r_den <= w_den[k];
            r_pay <= w_pay[k];
        end

        assign w_v[k+1]   = r_v;
        assign w_rem[k+1] = r_rem;
        assign w_lo[k+1]  = r_lo;
        assign w_quo[k+1] = r_quo;
        assign w_den[k+1] = r_den;
        assign w_pay[k+1] = r_pay;
    end

    assign o_valid = w_v[QB];
    assign o_quo   = w_quo[QB];
    assign o_pay   = w_pay[QB];

endmodule

`default_nettype wire

// ----- src/ardc_isqrt.sv -----
// Pipelined integer square root that settles one root bit per stage.
`default_nettype none

module ardc_isqrt #(
    parameter int SW = 34,
    parameter int PW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [SW-1:0]   i_sq,
    input  logic [PW-1:0]   i_pay,
    output logic            o_valid,
    output logic [SW/2-1:0] o_root,
    output logic [PW-1:0]   o_pay
);

    localparam int RW = SW / 2;

    logic          w_v    [0:RW];
    logic [SW-1:0] w_s    [0:RW];
    logic [RW+1:0] w_rem  [0:RW];
    logic [RW-1:0] w_root [0:RW];
    logic [PW-1:0] w_pay  [0:RW];

    assign w_v[0]    = i_valid;
    assign w_s[0]    = i_sq;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_pay[0]  = i_pay;

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic          r_v;
        logic [SW-1:0] r_s;
        logic [RW+1:0] r_rem;
        logic [RW-1:0] r_root;
        logic [PW-1:0] r_pay;
        logic [RW+3:0] w_try;
        logic [RW+3:0] w_trial;
        logic          w_ge;

        assign w_try   = {w_rem[k], w_s[k][SW-1-2*k -: 2]};
        assign w_trial = (RW+4)'({w_root[k], 2'b01});
        assign w_ge    = (w_try >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= w_v[k];
            end
            r_s    <= w_s[k];
            r_rem  <= w_ge ? (RW+2)'(w_try - w_trial) : (RW+2)'(w_try);
            r_root <= {w_root[k][RW-2:0], w_ge};
            r_pay  <= w_pay[k];
        end

        assign w_v[k+1]    = r_v;
        assign w_s[k+1]    = r_s;
        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
        assign w_pay[k+1]  = r_pay;
    end

    assign o_valid = w_v[RW];
    assign o_root  = w_root[RW];
    assign o_pay   = w_pay[RW];

endmodule

`default_nettype wire

// ----- src/axis_radial_deadzone_conditioner.sv -----
// Top level of the three-axis radial deadzone conditioner.
//
// A request is a three-axis sample in signed fixed point, 1.0 = 2^FRAC_BITS.
// It is accepted at a rising edge with i_start high and o_busy low; o_busy is
// always low, so a new request may enter in every cycle.
// Each request yields exactly one result on o_result, marked by o_valid for
// one cycle. Throughput is one request per cycle. The pipeline holds the
// quantizer divider (17 stages), the square root (17 stages) and the deadzone
// divider (FRAC_BITS + 2 stages), plus seven register stages around them.
// Results leave in acceptance order and the receiver cannot hold them off.
// Configuration registers are written through i_cfg_valid, i_cfg_index and
// i_cfg_data; o_cfg_ready is always high. Write them only while no request
// is in flight.
// Reset clears the configuration registers and all pipeline valid bits;
// requests in flight at reset are dropped.
`default_nettype none

module axis_radial_deadzone_conditioner
    import ardc_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_axis_in              i_req,
    output logic                  o_busy,
    output logic                  o_valid,
    output t_axis_out             o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [31:0]        ONE_U = 32'd1 << FRAC_BITS;
    localparam logic signed [31:0] ONE_S = $signed(ONE_U);
    localparam int QNW  = 31;
    localparam int QDW  = 14;
    localparam int QQB  = 17;
    localparam int SQW  = 34;
    localparam int LW   = SQW / 2;
    localparam int NUMW = 34;
    localparam int OMDW = FRAC_BITS + 1;
    localparam int DENW = LW + OMDW;
    localparam int DQB  = FRAC_BITS + 2;
    localparam int DNW  = NUMW + FRAC_BITS;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FLIP_MASK:       r_cfg.flip_mask       <= i_cfg_data[2:0];
                CFG_RESOLUTION_BITS: r_cfg.resolution_bits <= i_cfg_data[3:0];
                CFG_DEADZONE:        r_cfg.deadzone        <= i_cfg_data[13:0];
                CFG_ONE_SIDED_MASK:  r_cfg.one_sided_mask  <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Stage 1: axis flip.
    logic signed [16:0] w_in [3];
    logic               r_s1_valid;
    logic signed [16:0] r_s1_v [3];

    assign w_in[0] = 17'(i_req.axis_x);
    assign w_in[1] = 17'(i_req.axis_y);
    assign w_in[2] = 17'(i_req.axis_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_start;
        end
        for (int i = 0; i < 3; i++) begin
            r_s1_v[i] <= r_cfg.flip_mask[i] ? -w_in[i] : w_in[i];
        end
    end

    // Stage 2: quantizer product with the fraction bits dropped.
    logic              w_qen;
    logic [14:0]       w_h;
    logic [15:0]       w_mag1 [3];
    logic [14:0]       w_hp [3];
    logic [QNW-1:0]    w_prod [3];
    logic              r_s2_valid;
    logic [QNW-1:0]    r_s2_num [3];
    logic [QDW-1:0]    r_s2_den;
    logic [17:0]       r_s2_pay [3];

    assign w_qen = (r_cfg.resolution_bits >= 4'd2);
    assign w_h   = (15'd1 << 4'(r_cfg.resolution_bits - 4'd1)) - 15'd1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag1[i] = r_s1_v[i][16] ? 16'(-r_s1_v[i]) : 16'(r_s1_v[i]);
            w_hp[i]   = r_s1_v[i][16] ? 15'(w_h + 15'd1) : w_h;
            w_prod[i] = 31'(w_mag1[i]) * 31'(w_hp[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_den <= w_qen ? w_h[QDW-1:0] : QDW'(1);
        for (int i = 0; i < 3; i++) begin
            r_s2_num[i] <= (w_prod[i] >> FRAC_BITS) << FRAC_BITS;
            r_s2_pay[i] <= {w_qen, r_s1_v[i]};
        end
    end

    // Quantizer dividers.
    logic           w_q_valid [3];
    logic [QQB-1:0] w_q_quo   [3];
    logic [17:0]    w_q_pay   [3];

    for (genvar g = 0; g < 3; g++) begin : g_qdiv
        ardc_div #(
            .NW(QNW),
            .DW(QDW),
            .QB(QQB),
            .PW(18)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_s2_valid),
            .i_num   (r_s2_num[g]),
            .i_den   (r_s2_den),
            .i_pay   (r_s2_pay[g]),
            .o_valid (w_q_valid[g]),
            .o_quo   (w_q_quo[g]),
            .o_pay   (w_q_pay[g])
        );
    end

    // Stage 3: quantizer sign, floor and bypass.
    logic signed [17:0] w_r [3];
    logic signed [17:0] w_a3 [3];
    logic               r_s3_valid;
    logic signed [17:0] r_s3_a [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_r[i] = w_q_pay[i][16] ? -$signed({1'b0, w_q_quo[i]})
                                    : $signed({1'b0, w_q_quo[i]});
            if (32'(w_r[i]) < -ONE_S) begin
                w_r[i] = 18'(-ONE_S);
            end
            w_a3[i] = w_q_pay[i][17] ? w_r[i] : 18'($signed(w_q_pay[i][16:0]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= w_q_valid[0] & w_q_valid[1] & w_q_valid[2];
        end
        for (int i = 0; i < 3; i++) begin
            r_s3_a[i] <= w_a3[i];
        end
    end

    // Stage 4: squares. Stage 5: sum of squares.
    logic [16:0]        w_mag4 [3];
    logic               r_s4_valid;
    logic [SQW-1:0]     r_s4_sq [3];
    logic signed [17:0] r_s4_a [3];
    logic               r_s5_valid;
    logic [SQW-1:0]     r_s5_s;
    logic signed [17:0] r_s5_a [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag4[i] = r_s3_a[i][17] ? 17'(-r_s3_a[i]) : 17'(r_s3_a[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
        for (int i = 0; i < 3; i++) begin
            r_s4_sq[i] <= SQW'(w_mag4[i]) * SQW'(w_mag4[i]);
            r_s4_a[i]  <= r_s3_a[i];
            r_s5_a[i]  <= r_s4_a[i];
        end
        r_s5_s <= r_s4_sq[0] + r_s4_sq[1] + r_s4_sq[2];
    end

    // Vector length.
    logic          w_l_valid;
    logic [LW-1:0] w_len;
    logic [53:0]   w_l_pay;

    ardc_isqrt #(
        .SW(SQW),
        .PW(54)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s5_valid),
        .i_sq    (r_s5_s),
        .i_pay   ({r_s5_a[2], r_s5_a[1], r_s5_a[0]}),
        .o_valid (w_l_valid),
        .o_root  (w_len),
        .o_pay   (w_l_pay)
    );

    // Stage 6: deadzone scale numerators and the shared denominator.
    logic [31:0]        w_d;
    logic [OMDW-1:0]    w_omd;
    logic               w_lt;
    logic [LW-1:0]      w_ldiff;
    logic signed [17:0] w_a6 [3];
    logic [16:0]        w_mag6 [3];
    logic               r_s6_valid;
    logic [NUMW-1:0]    r_s6_num [3];
    logic [DENW-1:0]    r_s6_den;
    logic               r_s6_sign [3];
    logic               r_s6_zero;

    assign w_d     = (32'(r_cfg.deadzone) >= ONE_U) ? (ONE_U - 32'd1) : 32'(r_cfg.deadzone);
    assign w_omd   = OMDW'(ONE_U - w_d);
    assign w_lt    = (32'(w_len) < w_d);
    assign w_ldiff = LW'(32'(w_len) - w_d);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_a6[i]   = $signed(w_l_pay[18*i +: 18]);
            w_mag6[i] = w_a6[i][17] ? 17'(-w_a6[i]) : 17'(w_a6[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
        end else begin
            r_s6_valid <= w_l_valid;
        end
        r_s6_den  <= DENW'(w_len) * DENW'(w_omd);
        r_s6_zero <= (w_len == '0) || w_lt;
        for (int i = 0; i < 3; i++) begin
            r_s6_num[i]  <= NUMW'(w_mag6[i]) * NUMW'(w_ldiff);
            r_s6_sign[i] <= w_a6[i][17];
        end
    end

    // Deadzone dividers; a quotient of four or more is flagged as saturated.
    logic           w_sat [3];
    logic           w_d_valid [3];
    logic [DQB-1:0] w_d_quo [3];
    logic [2:0]     w_d_pay [3];

    for (genvar g = 0; g < 3; g++) begin : g_ddiv
        assign w_sat[g] = (64'(r_s6_num[g]) >= (64'(r_s6_den) << 2));

        ardc_div #(
            .NW(DNW),
            .DW(DENW),
            .QB(DQB),
            .PW(3)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_s6_valid),
            .i_num   ({r_s6_num[g], {FRAC_BITS{1'b0}}}),
            .i_den   (r_s6_den),
            .i_pay   ({r_s6_zero, w_sat[g], r_s6_sign[g]}),
            .o_valid (w_d_valid[g]),
            .o_quo   (w_d_quo[g]),
            .o_pay   (w_d_pay[g])
        );
    end

    // Output stage: deadzone zeroing, clamp, sign, one-sided mapping.
    logic [31:0]        w_omag [3];
    logic signed [31:0] w_o [3];
    logic               r_out_valid;
    t_axis_out          r_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_omag[i] = (w_d_pay[i][1] || (32'(w_d_quo[i]) > ONE_U)) ? ONE_U
                                                                      : 32'(w_d_quo[i]);
            if (w_d_pay[i][2]) begin
                w_o[i] = '0;
            end else if (w_d_pay[i][0]) begin
                w_o[i] = -$signed(w_omag[i]);
            end else begin
                w_o[i] = $signed(w_omag[i]);
            end
            if (r_cfg.one_sided_mask[i]) begin
                w_o[i] = (w_o[i] + ONE_S) >>> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_d_valid[0] & w_d_valid[1] & w_d_valid[2];
        end
        r_out.out_x <= w_o[0][15:0];
        r_out.out_y <= w_o[1][15:0];
        r_out.out_z <= w_o[2][15:0];
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

// ----- src/ardc_checker.sv -----
// Port-level checker for the conditioner and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module ardc_checker #(
    parameter int FRAC_BITS = 14
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid,
    input logic i_cfg_valid,
    input logic o_cfg_ready
);

    localparam int LAT = FRAC_BITS + 43;

    `ASSERT_ALWAYS(a_never_busy, i_clk, i_rst_n, !o_busy)
    `ASSERT_IMPLY(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready)
    `ASSERT_IMPLY(a_result_has_request, i_clk, i_rst_n, o_valid, $past(i_start, LAT))

endmodule

bind axis_radial_deadzone_conditioner ardc_checker #(
    .FRAC_BITS(FRAC_BITS)
) u_ardc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_valid     (o_valid),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);

`default_nettype wire

// ----- sim/axis_radial_deadzone_conditioner_tb.sv -----
// Self-checking testbench for the three-axis radial deadzone conditioner.
`timescale 1ns / 1ps

module axis_radial_deadzone_conditioner_tb;
    import ardc_pkg::*;

    localparam longint ONE       = 64'sd16384;
    localparam int     LATENCY   = 57;
    localparam int     MAX_CYCLE = 400000;

    class conditioner_scoreboard;
        logic [2:0]  flip;
        logic [3:0]  res_bits;
        logic [13:0] dz;
        logic [2:0]  one_sided;
        t_axis_out   expected[$];
        int          errors;

        function new();
            flip = 0;
            res_bits = 0;
            dz = 0;
            one_sided = 0;
            errors = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (t_cfg_idx'(idx))
                CFG_FLIP_MASK:       flip = data[2:0];
                CFG_RESOLUTION_BITS: res_bits = data[3:0];
                CFG_DEADZONE:        dz = data;
                CFG_ONE_SIDED_MASK:  one_sided = data[2:0];
                default: ;
            endcase
        endfunction

        function longint floor_sqrt(longint s);
            longint root;
            longint bitv;
            root = 0;
            bitv = 64'sd1 << 62;
            while (bitv > s) bitv = bitv >>> 2;
            while (bitv != 0) begin
                if (s >= root + bitv) begin
                    s = s - (root + bitv);
                    root = (root >>> 1) + bitv;
                end else begin
                    root = root >>> 1;
                end
                bitv = bitv >>> 2;
            end
            return root;
        endfunction

        function longint quantize(longint v);
            longint h;
            longint hp;
            longint t;
            longint r;
            h = (64'sd1 << (res_bits - 1)) - 1;
            hp = (v < 0) ? h + 1 : h;
            t = (v * hp) / ONE;
            r = (t * ONE) / h;
            return (r < -ONE) ? -ONE : r;
        endfunction

        function t_axis_out condition(t_axis_in v);
            longint    a[3];
            longint    d;
            longint    s;
            longint    len;
            bit        nonzero;
            t_axis_out o;
            a[0] = v.axis_x;
            a[1] = v.axis_y;
            a[2] = v.axis_z;
            nonzero = 0;
            for (int i = 0; i < 3; i++) begin
                if (flip[i]) a[i] = -a[i];
                if (res_bits >= 2) a[i] = quantize(a[i]);
                if (a[i] != 0) nonzero = 1;
            end
            if (nonzero) begin
                d = dz;
                if (d >= ONE) d = ONE - 1;
                s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
                len = floor_sqrt(s);
                for (int i = 0; i < 3; i++) begin
                    if (len < d) begin
                        a[i] = 0;
                    end else begin
                        a[i] = (a[i] * (len - d) * ONE) / (len * (ONE - d));
                        if (a[i] > ONE) a[i] = ONE;
                        if (a[i] < -ONE) a[i] = -ONE;
                    end
                end
            end
            for (int i = 0; i < 3; i++) begin
                if (one_sided[i]) a[i] = (a[i] + ONE) / 2;
            end
            o.out_x = a[0][15:0];
            o.out_y = a[1][15:0];
            o.out_z = a[2][15:0];
            return o;
        endfunction

        function void note_request(t_axis_in v);
            expected.push_back(condition(v));
        endfunction

        task report_mismatch(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_axis_out got);
            t_axis_out want;
            if (expected.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d %0d %0d",
                    got.out_x, got.out_y, got.out_z));
            end else begin
                want = expected.pop_front();
                if (got.out_x !== want.out_x)
                    report_mismatch($sformatf("out_x %0d, expected %0d", got.out_x, want.out_x));
                if (got.out_y !== want.out_y)
                    report_mismatch($sformatf("out_y %0d, expected %0d", got.out_y, want.out_y));
                if (got.out_z !== want.out_z)
                    report_mismatch($sformatf("out_z %0d, expected %0d", got.out_z, want.out_z));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    t_axis_in              i_req;
    logic                  o_busy;
    logic                  o_valid;
    t_axis_out             o_result;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    conditioner_scoreboard sb = new();
    int  cycle_count = 0;
    bit  allow_gaps = 1;

    axis_radial_deadzone_conditioner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_req       (i_req),
        .o_busy      (o_busy),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) sb.note_request(i_req);
            if (o_valid) sb.check_result(o_result);
            if (i_cfg_valid && o_cfg_ready) sb.set_register(i_cfg_index, i_cfg_data);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLE) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("** axis_radial_deadzone_conditioner: FAILED **");
            $finish;
        end
    end

    task automatic write_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        while (sb.expected.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic configure(logic [2:0] flip, logic [3:0] res, logic [13:0] dz,
                             logic [2:0] os);
        wait_idle();
        write_register(CFG_FLIP_MASK, 14'(flip));
        write_register(CFG_RESOLUTION_BITS, 14'(res));
        write_register(CFG_DEADZONE, dz);
        write_register(CFG_ONE_SIDED_MASK, 14'(os));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_request(logic signed [15:0] x, logic signed [15:0] y,
                                logic signed [15:0] z);
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_req.axis_x <= x;
        i_req.axis_y <= y;
        i_req.axis_z <= z;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic send_directed();
        send_request(0, 0, 0);
        send_request(16384, 0, 0);
        send_request(-16384, -16384, -16384);
        send_request(32767, -32768, 0);
        send_request(1, 0, 0);
        send_request(-1, -1, -1);
        i_start <= 1'b0;
    endtask

    function automatic logic signed [15:0] random_axis();
        logic signed [15:0] picks[7] = '{-32768, -16384, -1, 0, 1, 16384, 32767};
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return picks[$urandom_range(0, 6)];
            2: return 16'($signed($urandom_range(0, 400)) - 200);
            3: return 0;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic logic [13:0] random_deadzone();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 14'd16383;
            2: return 14'($urandom_range(0, 2000));
            default: return 14'($urandom);
        endcase
    endfunction

    initial begin
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_req       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed();
        configure(3'd7, 4'd14, 14'd16383, 3'd7);
        send_directed();
        configure(3'd5, 4'd15, 14'd8192, 3'd2);
        send_directed();
        configure(3'd2, 4'd2, 14'd0, 3'd0);
        send_directed();

        for (int phase = 0; phase < 10; phase++) begin
            if (phase == 0)
                configure(3'd0, 4'd0, 14'd0, 3'd0);
            else if (phase == 1)
                configure(3'd7, 4'd1, 14'd16383, 3'd7);
            else
                configure(3'($urandom), 4'($urandom), random_deadzone(), 3'($urandom));
            if (phase == 9) allow_gaps = 0;
            for (int n = 0; n < 125; n++) send_request(random_axis(), random_axis(),
                random_axis());
            i_start <= 1'b0;
        end

        wait_idle();
        if (sb.expected.size() != 0)
            sb.report_mismatch("expected results never arrived");
        if (sb.errors == 0) begin
            $display("** axis_radial_deadzone_conditioner: PASSED **");
        end else begin
            $display("** axis_radial_deadzone_conditioner: FAILED **");
        end
        $finish;
    end

endmodule
